### hdl/gsd_pkg.sv
// Package with the payload types, state encoding and constants of the grid stencil core.
`timescale 1ns / 1ps
package gsd_pkg;
	localparam int LEVEL_BITS = 22;
	localparam int SUM_BITS   = LEVEL_BITS + 4;
	localparam int RATE_BITS  = 16;
	localparam int WIDTH_BITS = 11;
	localparam int HEIGHT_BITS = 13;
	localparam int MAX_HEIGHT = 4096;
	localparam int CELL_BITS  = 2 * LEVEL_BITS + 1;
	localparam int CFG_BITS   = 22;
	localparam int RECIP_SHIFT = 33;
	localparam logic [29:0] RECIP_NINE = 30'd954437177;

	localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_HOME_RATE      = 3'd2;
	localparam logic [2:0] REG_FOOD_RATE      = 3'd3;
	localparam logic [2:0] REG_HOME_THRESHOLD = 3'd4;
	localparam logic [2:0] REG_FOOD_THRESHOLD = 3'd5;

	localparam logic KIND_CELL  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic                  kind;
		logic [LEVEL_BITS-1:0] home_level;
		logic [LEVEL_BITS-1:0] food_level;
		logic                  is_wall;
	} gsd_in_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] new_home;
		logic [LEVEL_BITS-1:0] new_food;
		logic                  frame_end;
	} gsd_out_t;

	typedef struct packed {
		logic                  wall;
		logic [LEVEL_BITS-1:0] food;
		logic [LEVEL_BITS-1:0] home;
	} gsd_cell_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_DIV,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} gsd_state_t;
endpackage

### hdl/grid_stencil_diffusion_core.sv
// Top level of the grid stencil diffusion core.
`timescale 1ns / 1ps
// Cells enter in raster order; each accepted beat is handled alone. A beat that
// yields a result holds the input through the read, sum, divide, multiply, finish
// and output states, longer while its result is stalled; a beat without a result
// holds it through the read state only; an early flush is dropped with no stall.
// The cost is set by the single line memory read-modify-write and the
// sum, divide-by-nine and blend multiplier steps run in turn.
// Results trail their cell by width+1 beats; width+1 flush beats end a frame.
// Geometry writes take effect at the next frame start, rates and thresholds at once.
module grid_stencil_diffusion_core import gsd_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cell_valid,
	output logic                  cell_stall,
	input  gsd_in_t               cell_data,
	output logic                  result_valid,
	input  logic                  result_stall,
	output gsd_out_t              result,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_data
);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 2);
	localparam int RW = HEIGHT_BITS;
	localparam int FW_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

	// configuration
	logic [WIDTH_BITS-1:0]  grid_width_q;
	logic [HEIGHT_BITS-1:0] grid_height_q;
	logic [RATE_BITS-1:0]   home_rate_q, food_rate_q;
	logic [LEVEL_BITS-1:0]  home_thr_q, food_thr_q;
	logic [CW-1:0]          fw_q;
	logic [RW-1:0]          fh_q;

	// counters
	logic [CW-1:0] col_q, ecol_q;
	logic [RW-1:0] row_q, erow_q;

	gsd_state_t state_q, state_d;

	logic [2*CELL_BITS-1:0] mem [MAX_WIDTH];
	logic [2*CELL_BITS-1:0] rd_q;
	logic [AW-1:0]          addr_q;
	gsd_cell_t              v_q;
	gsd_cell_t              win_q [9];
	logic                   emit_q, fend_q;
	logic                   rlo_q, rhi_q, clo_q, chi_q;
	logic [SUM_BITS-1:0]    hsum_q, fsum_q;
	logic [LEVEL_BITS-1:0]  havg_q, favg_q;
	logic                   hgt_q, fgt_q;
	logic [LEVEL_BITS+16:0] hp1_q, hp2_q, fp1_q, fp2_q;
	gsd_out_t               result_q;
	logic                   out_valid_q;

	logic accept, early_flush, in_frame, emits;
	logic [CW-1:0] wrap_w;
	logic [CW-1:0] clamp_w;
	logic [RW-1:0] clamp_h;

	assign cell_stall   = (state_q != ST_IDLE);
	assign accept       = cell_valid && !cell_stall;
	assign in_frame     = (row_q < fh_q);
	assign early_flush  = in_frame && (cell_data.kind == KIND_FLUSH);
	assign emits        = !((row_q == '0) || ((row_q == RW'(1)) && (col_q == '0)));
	assign wrap_w       = fw_q - CW'(1);
	assign result_valid = out_valid_q;
	assign result       = result_q;

	always_comb begin
		clamp_w = CW'(grid_width_q);
		if (grid_width_q == '0) clamp_w = CW'(1);
		if ({1'b0, grid_width_q} > (WIDTH_BITS+1)'(MAX_WIDTH)) clamp_w = CW'(MAX_WIDTH);
		clamp_h = grid_height_q;
		if (grid_height_q == '0) clamp_h = RW'(1);
		if (grid_height_q > RW'(MAX_HEIGHT)) clamp_h = RW'(MAX_HEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= WIDTH_BITS'(1024);
			grid_height_q <= HEIGHT_BITS'(1024);
			home_rate_q   <= RATE_BITS'(6554);
			food_rate_q   <= RATE_BITS'(655);
			home_thr_q    <= '0;
			food_thr_q    <= LEVEL_BITS'(5120);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:     grid_width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_GRID_HEIGHT:    grid_height_q <= cfg_data[HEIGHT_BITS-1:0];
				REG_HOME_RATE:      home_rate_q   <= cfg_data[RATE_BITS-1:0];
				REG_FOOD_RATE:      food_rate_q   <= cfg_data[RATE_BITS-1:0];
				REG_HOME_THRESHOLD: home_thr_q    <= cfg_data[LEVEL_BITS-1:0];
				REG_FOOD_THRESHOLD: food_thr_q    <= cfg_data[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Frame counters advance at acceptance; the frame-end beat restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ecol_q <= '0;
			erow_q <= '0;
			fw_q   <= CW'(FW_RESET);
			fh_q   <= RW'(1024);
		end else if (accept && !early_flush) begin
			if (emits && (erow_q == fh_q - RW'(1)) && (ecol_q == wrap_w)) begin
				col_q  <= '0;
				row_q  <= '0;
				ecol_q <= '0;
				erow_q <= '0;
				fw_q   <= clamp_w;
				fh_q   <= clamp_h;
			end else begin
				if (col_q == wrap_w) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (emits) begin
					if (ecol_q == wrap_w) begin
						ecol_q <= '0;
						erow_q <= erow_q + RW'(1);
					end else begin
						ecol_q <= ecol_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !early_flush) begin
			rd_q   <= mem[col_q[AW-1:0]];
			addr_q <= col_q[AW-1:0];
			v_q    <= in_frame ? gsd_cell_t'{cell_data.is_wall, cell_data.food_level,
			                                 cell_data.home_level}
			                   : gsd_cell_t'('0);
			emit_q <= emits;
			fend_q <= (erow_q == fh_q - RW'(1)) && (ecol_q == wrap_w);
			rlo_q  <= (erow_q != '0);
			rhi_q  <= (erow_q + RW'(1) < fh_q);
			clo_q  <= (ecol_q != '0);
			chi_q  <= (ecol_q + CW'(1) < fw_q);
		end
		if (state_q == ST_READ) begin
			mem[addr_q] <= {rd_q[CELL_BITS-1:0], v_q};
			for (int k = 0; k < 3; k++) begin
				win_q[k*3+0] <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= gsd_cell_t'(rd_q[2*CELL_BITS-1:CELL_BITS]);
			win_q[5] <= gsd_cell_t'(rd_q[CELL_BITS-1:0]);
			win_q[8] <= v_q;
		end
	end

	// Neighborhood sums with off-grid taps masked to zero.
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			logic [SUM_BITS-1:0] hs, fs;
			logic rok, cok;
			hs = '0;
			fs = '0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					rok = (k == 0) ? rlo_q : ((k == 2) ? rhi_q : 1'b1);
					cok = (j == 0) ? clo_q : ((j == 2) ? chi_q : 1'b1);
					if (rok && cok) begin
						hs = hs + SUM_BITS'(win_q[k*3+j].home);
						fs = fs + SUM_BITS'(win_q[k*3+j].food);
					end
				end
			end
			hsum_q <= hs;
			fsum_q <= fs;
		end
	end

	// Divide by nine through a reciprocal that is exact over the sum range.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			logic [SUM_BITS+29:0] hq, fq;
			hq = SUM_BITS'(hsum_q) * RECIP_NINE;
			fq = SUM_BITS'(fsum_q) * RECIP_NINE;
			havg_q <= hq[RECIP_SHIFT +: LEVEL_BITS];
			favg_q <= fq[RECIP_SHIFT +: LEVEL_BITS];
			hgt_q  <= hsum_q > ({home_thr_q, 3'b000} + SUM_BITS'(home_thr_q));
			fgt_q  <= fsum_q > ({food_thr_q, 3'b000} + SUM_BITS'(food_thr_q));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			hp1_q <= (LEVEL_BITS+17)'(17'h10000 - 17'(home_rate_q))
			         * (LEVEL_BITS+17)'(win_q[4].home);
			hp2_q <= (LEVEL_BITS+17)'(home_rate_q) * (LEVEL_BITS+17)'(havg_q);
			fp1_q <= (LEVEL_BITS+17)'(17'h10000 - 17'(food_rate_q))
			         * (LEVEL_BITS+17)'(win_q[4].food);
			fp2_q <= (LEVEL_BITS+17)'(food_rate_q) * (LEVEL_BITS+17)'(favg_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			logic [LEVEL_BITS+17:0] hb, fb;
			hb = {1'b0, hp1_q} + {1'b0, hp2_q};
			fb = {1'b0, fp1_q} + {1'b0, fp2_q};
			result_q.new_home  <= (!win_q[4].wall && hgt_q) ? hb[16 +: LEVEL_BITS]
			                                                : win_q[4].home;
			result_q.new_food  <= (!win_q[4].wall && fgt_q) ? fb[16 +: LEVEL_BITS]
			                                                : win_q[4].food;
			result_q.frame_end <= fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN) out_valid_q <= 1'b1;
			else if (out_valid_q && !result_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && !early_flush) state_d = ST_READ;
			ST_READ: state_d = emit_q ? ST_SUM : ST_IDLE;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (!result_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hdl/gsd_checker.sv
// Port-level checker for the grid stencil diffusion core and its bind.
`timescale 1ns / 1ps
module gsd_checker import gsd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     cell_stall,
	input logic     result_valid,
	input logic     result_stall,
	input gsd_out_t result
);
	// A waiting result blocks new input beats.
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cell_stall) else $error("input open while result waits");

	// A result only appears after the core has been busy with an item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cell_stall)) else $error("result without work");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");
endmodule

bind grid_stencil_diffusion_core gsd_checker u_gsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cell_stall   (cell_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
